FILE: rtl/core/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

	localparam int FIELD_W = 64;
	localparam int DATA_WIDTH_DEF = 64;

	typedef enum logic [1:0] {
		ST_VALID,
		ST_OVERFLOW,
		ST_NEGZERO
	} status_t;

	typedef struct packed {
		logic    byp;
		logic    lneg;
		logic    diff;
		logic    nz_en;
		status_t st;
	} ctl_t;

endpackage

FILE: rtl/core/srs_prep.sv
`timescale 1ns / 1ps

module srs_prep #(
	parameter int DATA_WIDTH = srs_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  logic                  action,
	input  logic [DATA_WIDTH-1:0] lft,
	input  logic [DATA_WIDTH-1:0] rht,
	input  logic                  allow,
	output logic                  vld_s1,
	output srs_pkg::ctl_t         ctl_s1,
	output logic [DATA_WIDTH-1:0] ml_s1,
	output logic [DATA_WIDTH-1:0] dvd_s1,
	output logic [DATA_WIDTH-1:0] rem_s1
);
	import srs_pkg::*;

	localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic                  lneg;
	logic                  rneg;
	logic [DATA_WIDTH-1:0] neg_l;
	logic [DATA_WIDTH-1:0] neg_r;
	logic [DATA_WIDTH-1:0] ml;
	logic [DATA_WIDTH-1:0] mr;
	ctl_t                  ctl;
	logic [DATA_WIDTH-1:0] rem;
	logic [DATA_WIDTH-1:0] dvd;

	assign lneg  = lft[DATA_WIDTH-1];
	assign rneg  = rht[DATA_WIDTH-1];
	assign neg_l = '0 - lft;
	assign neg_r = '0 - rht;
	assign ml    = lneg ? neg_l : lft;
	assign mr    = rneg ? neg_r : rht;

	always_comb begin
		ctl.byp   = 1'b1;
		ctl.lneg  = lneg;
		ctl.diff  = lneg ^ rneg;
		ctl.nz_en = lneg & allow;
		ctl.st    = ST_VALID;
		rem       = '0;
		dvd       = mr;
		if (!action) begin
			if (rht == MIN_VAL) begin
				ctl.st = ST_OVERFLOW;
			end else begin
				rem = mr;
			end
		end else if (lft == '0 || rht == '0) begin
			rem = lneg ? neg_r : rht;
			if (lneg && rht == '0 && allow) begin
				ctl.st = ST_NEGZERO;
			end
		end else if (lft == MIN_VAL || rht == MIN_VAL) begin
			ctl.st = ST_OVERFLOW;
		end else begin
			ctl.byp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl;
		ml_s1  <= ml;
		dvd_s1 <= dvd;
		rem_s1 <= rem;
	end

endmodule

FILE: rtl/core/srs_div_stage.sv
`timescale 1ns / 1ps

module srs_div_stage #(
	parameter int DATA_WIDTH = srs_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  srs_pkg::ctl_t         ctl,
	input  logic [DATA_WIDTH-1:0] ml,
	input  logic [DATA_WIDTH-1:0] dvd,
	input  logic [DATA_WIDTH-1:0] rem,
	output logic                  vld_s2,
	output srs_pkg::ctl_t         ctl_s2,
	output logic [DATA_WIDTH-1:0] ml_s2,
	output logic [DATA_WIDTH-1:0] dvd_s2,
	output logic [DATA_WIDTH-1:0] rem_s2
);
	import srs_pkg::*;

	logic [DATA_WIDTH-1:0] sh;
	logic [DATA_WIDTH-1:0] rem_n;

	// The partial remainder stays below the modulus, so the shift never loses a bit.
	assign sh = {rem[DATA_WIDTH-2:0], dvd[DATA_WIDTH-1]};

	always_comb begin
		rem_n = rem;
		if (!ctl.byp) begin
			rem_n = (sh >= ml) ? (sh - ml) : sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl;
		ml_s2  <= ml;
		dvd_s2 <= {dvd[DATA_WIDTH-2:0], 1'b0};
		rem_s2 <= rem_n;
	end

endmodule

FILE: rtl/core/srs_final.sv
`timescale 1ns / 1ps

module srs_final #(
	parameter int DATA_WIDTH = srs_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  srs_pkg::ctl_t         ctl,
	input  logic [DATA_WIDTH-1:0] ml,
	input  logic [DATA_WIDTH-1:0] rem,
	output logic                  vld_s3,
	output logic [DATA_WIDTH-1:0] res_s3,
	output srs_pkg::status_t      st_s3
);
	import srs_pkg::*;

	logic                  rz;
	logic                  adj;
	logic [DATA_WIDTH-1:0] p;
	logic [DATA_WIDTH-1:0] res;
	status_t               st;

	// Floored correction and the sign of the modulus fold into one subtraction.
	assign rz  = (rem == '0);
	assign adj = ctl.diff & !rz;
	assign p   = adj ? ml : '0;

	always_comb begin
		if (ctl.byp) begin
			res = rem;
			st  = ctl.st;
		end else begin
			res = (adj ^ ctl.lneg) ? (p - rem) : (rem - p);
			st  = (ctl.nz_en && rz) ? ST_NEGZERO : ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= res;
		st_s3  <= st;
	end

endmodule

FILE: rtl/core/signed_floored_residue.sv
`timescale 1ns / 1ps

// Channel       Ports                                        Handshake
// request       action, left_value, right_value              start & !busy
// result        result_value, status                         done, one cycle
// config        cfg_wdata (allow_neg_zero)                   cfg_we
//
// A request is taken every cycle; busy stays low.
// The pipeline has one operand stage, one restoring
// remainder stage per bit, and one stage for the floored correction.
// Reset clears the valid bits and allow_neg_zero.
// The receiver cannot stall, so the pipeline never holds.

module signed_floored_residue #(
	parameter int DATA_WIDTH = srs_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [srs_pkg::FIELD_W-1:0] left_value,
	input  logic [srs_pkg::FIELD_W-1:0] right_value,
	output logic                        done,
	output logic [srs_pkg::FIELD_W-1:0] result_value,
	output logic [1:0]                  status,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata
);
	import srs_pkg::*;

	logic                  allow_q;
	logic                  vld_c [0:DATA_WIDTH];
	ctl_t                  ctl_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] ml_c  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dvd_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
	logic                  vld_s3;
	logic [DATA_WIDTH-1:0] res_s3;
	status_t               st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
		end else if (cfg_we) begin
			allow_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	srs_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & !busy),
		.action (action),
		.lft    (left_value[DATA_WIDTH-1:0]),
		.rht    (right_value[DATA_WIDTH-1:0]),
		.allow  (allow_q),
		.vld_s1 (vld_c[0]),
		.ctl_s1 (ctl_c[0]),
		.ml_s1  (ml_c[0]),
		.dvd_s1 (dvd_c[0]),
		.rem_s1 (rem_c[0])
	);

	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
		srs_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vld_c[k]),
			.ctl    (ctl_c[k]),
			.ml     (ml_c[k]),
			.dvd    (dvd_c[k]),
			.rem    (rem_c[k]),
			.vld_s2 (vld_c[k+1]),
			.ctl_s2 (ctl_c[k+1]),
			.ml_s2  (ml_c[k+1]),
			.dvd_s2 (dvd_c[k+1]),
			.rem_s2 (rem_c[k+1])
		);
	end

	srs_final #(.DATA_WIDTH(DATA_WIDTH)) u_final (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_c[DATA_WIDTH]),
		.ctl    (ctl_c[DATA_WIDTH]),
		.ml     (ml_c[DATA_WIDTH]),
		.rem    (rem_c[DATA_WIDTH]),
		.vld_s3 (vld_s3),
		.res_s3 (res_s3),
		.st_s3  (st_s3)
	);

	assign done         = vld_s3;
	assign result_value = FIELD_W'($signed(res_s3));
	assign status       = st_s3;

endmodule

FILE: verif/signed_floored_residue_test.sv
`timescale 1ns / 1ps

module signed_floored_residue_test;

	import srs_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_REQUESTS = 325;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] WIDTH_MASK = (DW == 64) ? '1 : ((64'd1 << DW) - 64'd1);
	localparam logic [63:0] WIDTH_SIGN = 64'd1 << (DW - 1);

	typedef struct {
		logic [63:0] value;
		status_t     st;
	} residue_t;

	typedef struct {
		bit          nz_en;
		bit          act;
		logic [63:0] lv;
		logic [63:0] rv;
		bit          typed;
		logic [63:0] want;
		status_t     want_st;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        action = 1'b0;
	logic [63:0] left_value = '0;
	logic [63:0] right_value = '0;
	logic        done;
	logic [63:0] result_value;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	residue_t pending_residues [$];
	logic     neg_zero_en = 1'b0;
	int       failures = 0;
	int       results_seen = 0;
	int       abs_requests = 0;
	int       residue_requests = 0;
	int       overflow_seen = 0;
	int       neg_zero_seen = 0;
	int       quiet_cycles = 0;

	request_row_t directed_rows [26] = '{
		'{0, 0, 0, 0, 1, 0, ST_VALID},
		'{0, 0, 0, MOST_POS, 1, MOST_POS, ST_VALID},
		'{0, 0, 0, MOST_NEG, 1, 0, ST_OVERFLOW},
		'{0, 0, MOST_NEG, -1, 1, 1, ST_VALID},
		'{0, 0, 5, -77, 1, 77, ST_VALID},
		'{0, 1, 0, MOST_NEG, 1, MOST_NEG, ST_VALID},
		'{0, 1, MOST_NEG, 0, 1, 0, ST_VALID},
		'{0, 1, MOST_NEG, 3, 1, 0, ST_OVERFLOW},
		'{0, 1, 7, MOST_NEG, 1, 0, ST_OVERFLOW},
		'{0, 1, 5, 13, 1, 3, ST_VALID},
		'{0, 1, 5, -13, 1, 2, ST_VALID},
		'{0, 1, -5, 13, 1, -2, ST_VALID},
		'{0, 1, -5, -13, 1, -3, ST_VALID},
		'{0, 1, -5, 10, 1, 0, ST_VALID},
		'{0, 1, MOST_POS, -1, 1, MOST_POS - 64'd1, ST_VALID},
		'{0, 1, -1, MOST_POS, 1, 0, ST_VALID},
		'{0, 1, MOST_POS, MOST_POS, 1, 0, ST_VALID},
		'{0, 1, 64'h0000_0123_4567_89AB, 64'hFEDC_BA98_7654_3210, 0, 0, ST_VALID},
		'{0, 1, 64'hF000_0000_0000_0001, 64'h7FFF_0000_FFFF_0000, 0, 0, ST_VALID},
		'{1, 1, -5, 10, 1, 0, ST_NEGZERO},
		'{1, 1, -3, 0, 1, 0, ST_NEGZERO},
		'{1, 1, MOST_NEG, 0, 1, 0, ST_NEGZERO},
		'{1, 1, 0, -9, 1, -9, ST_VALID},
		'{1, 1, 5, 10, 1, 0, ST_VALID},
		'{1, 0, -4, 0, 1, 0, ST_VALID},
		'{1, 1, -7, MOST_NEG + 64'd7, 0, 0, ST_VALID}
	};

	signed_floored_residue #(
		.DATA_WIDTH(DW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.left_value(left_value),
		.right_value(right_value),
		.done(done),
		.result_value(result_value),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic residue_t floored_residue_of(logic act, logic [63:0] lv, logic [63:0] rv,
			logic nz_en);
		residue_t    res;
		logic [63:0] l;
		logic [63:0] r;
		logic [63:0] ml;
		logic [63:0] mr;
		logic [63:0] rem;
		logic [63:0] raw;
		l = lv & WIDTH_MASK;
		r = rv & WIDTH_MASK;
		res.st = ST_VALID;
		raw = '0;
		if (!act) begin
			if (r == WIDTH_SIGN)
				res.st = ST_OVERFLOW;
			else
				raw = (r & WIDTH_SIGN) ? ((64'd0 - r) & WIDTH_MASK) : r;
		end else if (l != 0 && r != 0 && (l == WIDTH_SIGN || r == WIDTH_SIGN)) begin
			res.st = ST_OVERFLOW;
		end else begin
			if (l == 0 || r == 0) begin
				rem = r;
			end else begin
				ml = (l & WIDTH_SIGN) ? ((64'd0 - l) & WIDTH_MASK) : l;
				mr = (r & WIDTH_SIGN) ? ((64'd0 - r) & WIDTH_MASK) : r;
				rem = mr % ml;
				if (((l & WIDTH_SIGN) != (r & WIDTH_SIGN)) && rem != 0)
					rem = ml - rem;
			end
			if (l & WIDTH_SIGN) begin
				if (rem == 0 && nz_en)
					res.st = ST_NEGZERO;
				raw = (64'd0 - rem) & WIDTH_MASK;
			end else begin
				raw = rem;
			end
		end
		res.value = (raw & WIDTH_SIGN) ? (raw | ~WIDTH_MASK) : raw;
		return res;
	endfunction

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = MOST_NEG;
			2: v = MOST_POS;
			3: v = $urandom_range(1) ? 64'd1 : '1;
			4, 5: begin
				v = 64'($urandom_range(20));
				if ($urandom_range(1))
					v = -v;
			end
			6, 7: v = {$urandom, $urandom};
			default: begin
				v = {$urandom, $urandom} >> $urandom_range(63);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic void report_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	task automatic issue_request(input logic a, input logic [63:0] l, input logic [63:0] r,
			input residue_t want);
		start <= 1'b1;
		action <= a;
		left_value <= l;
		right_value <= r;
		do
			@(posedge clk);
		while (busy);
		pending_residues.push_back(want);
		if (a)
			residue_requests++;
		else
			abs_requests++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_residues.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_neg_zero_enable(input logic v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		neg_zero_en = v;
	endtask

	always @(posedge clk) begin : check_results
		residue_t head;
		if (arst_n && done) begin
			results_seen++;
			if (pending_residues.size() == 0) begin
				report_failure($sformatf(
					"Unexpected result %h status %0d with no request waiting.",
					result_value, status));
			end else begin
				head = pending_residues.pop_front();
				if (result_value !== head.value || status !== head.st)
					report_failure($sformatf(
						"Result %0d differs: expected %h status %0d, got %h status %0d.",
						results_seen, head.value, head.st, result_value, status));
				if (head.st == ST_OVERFLOW)
					overflow_seen++;
				if (head.st == ST_NEGZERO)
					neg_zero_seen++;
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timed out after %0d cycles without a request or result.", quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		residue_t    want;
		logic        a;
		logic [63:0] l;
		logic [63:0] r;
		logic [63:0] k;
		int          idle_pct [4];
		idle_pct = '{0, 61, 0, 23};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].nz_en != neg_zero_en)
				write_neg_zero_enable(directed_rows[i].nz_en);
			if (directed_rows[i].typed) begin
				want.value = directed_rows[i].want;
				want.st = directed_rows[i].want_st;
			end else begin
				want = floored_residue_of(directed_rows[i].act, directed_rows[i].lv,
					directed_rows[i].rv, neg_zero_en);
			end
			issue_request(directed_rows[i].act, directed_rows[i].lv, directed_rows[i].rv,
				want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			write_neg_zero_enable(ph[0]);
			repeat (PHASE_REQUESTS) begin
				if ($urandom_range(149) == 0)
					drain_results();
				while ($urandom_range(99) < idle_pct[ph]) begin
					start <= 1'b0;
					@(posedge clk);
				end
				a = ($urandom_range(4) != 0);
				l = random_operand();
				if (a && $urandom_range(3) == 0) begin
					// Exact multiples drive the zero-remainder and negative-zero paths.
					k = 64'($urandom_range(9) + 1);
					if ($urandom_range(1))
						k = -k;
					r = l * k;
				end else begin
					r = random_operand();
				end
				issue_request(a, l, r, floored_residue_of(a, l, r, neg_zero_en));
			end
		end

		drain_results();
		repeat (DW + 8) @(posedge clk);
		if (pending_residues.size() != 0)
			report_failure($sformatf("%0d expected results never arrived.",
				pending_residues.size()));
		$display("Covered %0d requests (%0d absolute, %0d residue) over four pacing phases,",
			abs_requests + residue_requests, abs_requests, residue_requests);
		$display(
			"with negative zero enabled and disabled: %0d overflow, %0d negative zero, %0d failures.",
			overflow_seen, neg_zero_seen, failures);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
